### rtl/hsp_pkg.sv
package hsp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned IdW    = 16;
  localparam int unsigned ValueW = 32;
  localparam int unsigned ShiftW = 40;
  localparam int unsigned PosW   = 3;

  // position of the byte that completes a six-byte entry
  localparam logic [PosW-1:0] ENTRY_LAST_POS = 3'd5;

  localparam logic [ValueW-1:0] WINDOW_MAX = 32'd2147483647;
  localparam logic [ValueW-1:0] FRAME_MIN  = 32'd16384;
  localparam logic [ValueW-1:0] FRAME_MAX  = 32'd16777215;

  typedef enum logic [2:0] {
    ST_APPLIED     = 3'd0,
    ST_BAD_VALUE   = 3'd1,
    ST_UNKNOWN_ID  = 3'd2,
    ST_TRUNCATED   = 3'd3,
    ST_SKIPPED     = 3'd4
  } status_e;

  typedef enum logic [IdW-1:0] {
    ID_TABLE_SIZE        = 16'd1,
    ID_ENABLE_PUSH       = 16'd2,
    ID_MAX_STREAMS       = 16'd3,
    ID_WINDOW_SIZE       = 16'd4,
    ID_MAX_FRAME_SIZE    = 16'd5,
    ID_MAX_HEADER_LIST   = 16'd6
  } setting_id_e;

  typedef struct packed {
    logic [31:0] table_size;
    logic        push_enabled;
    logic [31:0] max_streams;
    logic [30:0] window_size;
    logic [23:0] frame_size_limit;
    logic [31:0] header_list_limit;
  } settings_t;

  localparam settings_t SETTINGS_RESET = '{
    table_size:        32'd4096,
    push_enabled:      1'b1,
    max_streams:       32'hFFFF_FFFF,
    window_size:       31'd65535,
    frame_size_limit:  24'd16384,
    header_list_limit: 32'hFFFF_FFFF
  };

  typedef struct packed {
    logic [IdW-1:0]    entry_id;
    logic [ValueW-1:0] entry_value;
    status_e           entry_status;
    logic              frame_done;
    logic              frame_ok;
    settings_t         settings;
  } result_t;

endpackage

### rtl/hsp_entry_check.sv
module hsp_entry_check
  import hsp_pkg::*;
(
  input  logic [IdW-1:0]    id_i,
  input  logic [ValueW-1:0] value_i,
  input  settings_t         cur_i,
  output status_e           status_o,
  output settings_t         next_o
);

  always_comb begin
    next_o   = cur_i;
    status_o = ST_APPLIED;
    unique case (id_i)
      ID_TABLE_SIZE: next_o.table_size = value_i;
      ID_ENABLE_PUSH: begin
        if (value_i > 32'd1) status_o = ST_BAD_VALUE;
        else next_o.push_enabled = value_i[0];
      end
      ID_MAX_STREAMS: next_o.max_streams = value_i;
      ID_WINDOW_SIZE: begin
        if (value_i > WINDOW_MAX) status_o = ST_BAD_VALUE;
        else next_o.window_size = value_i[30:0];
      end
      ID_MAX_FRAME_SIZE: begin
        if (value_i < FRAME_MIN || value_i > FRAME_MAX) status_o = ST_BAD_VALUE;
        else next_o.frame_size_limit = value_i[23:0];
      end
      ID_MAX_HEADER_LIST: next_o.header_list_limit = value_i;
      default: status_o = ST_UNKNOWN_ID;
    endcase
  end

endmodule

### rtl/hsp_out_reg.sv
module hsp_out_reg
  import hsp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    free_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) valid_d = 1'b1;
    else if (!out_stall_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

### rtl/http2_settings_payload_parser_core.sv
// a byte is held in the input register; a result it gives loads into the output register
// throughput: one byte per cycle; only a byte with a result waits, on a stalled full output
// the parse state and stored settings advance once per byte, in a single registered pass
// reset: asynchronous, active low; clears the entry position, shift and error flag, and
// loads the stored settings with their protocol defaults
module http2_settings_payload_parser_core
  import hsp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ByteW-1:0]  data_byte_i,
  input  logic              last_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [IdW-1:0]    entry_id_o,
  output logic [ValueW-1:0] entry_value_o,
  output logic [2:0]        entry_status_o,
  output logic              frame_done_o,
  output logic              frame_ok_o,
  output logic [31:0]       table_size_o,
  output logic              push_enabled_o,
  output logic [31:0]       max_streams_o,
  output logic [30:0]       window_size_o,
  output logic [23:0]       frame_size_limit_o,
  output logic [31:0]       header_list_limit_o
);

  // input register
  logic             s1_valid_q, s1_valid_d;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_last_q;

  // parse state
  logic [PosW-1:0]   pos_q, pos_d;
  logic [ShiftW-1:0] shift_q, shift_d;
  logic              err_q, err_d;
  settings_t         set_q, set_d;

  logic              complete;
  logic [IdW-1:0]    cur_id;
  logic [ValueW-1:0] cur_value;
  status_e           chk_status;
  settings_t         chk_next;
  logic              err_mid;
  logic              emit;
  result_t           res;
  result_t           res_q;
  logic              out_free;
  logic              s1_adv;
  logic              in_accept;

  assign complete  = pos_q >= ENTRY_LAST_POS;
  assign cur_id    = shift_q[39:24];
  assign cur_value = {shift_q[23:0], s1_byte_q};

  hsp_entry_check u_check (
    .id_i     (cur_id),
    .value_i  (cur_value),
    .cur_i    (set_q),
    .status_o (chk_status),
    .next_o   (chk_next)
  );

  always_comb begin
    pos_d   = pos_q;
    shift_d = shift_q;
    err_mid = err_q;
    set_d   = set_q;
    emit    = 1'b0;
    res.entry_id     = '0;
    res.entry_value  = '0;
    res.entry_status = ST_APPLIED;
    if (complete) begin
      res.entry_id    = cur_id;
      res.entry_value = cur_value;
      if (err_q) begin
        res.entry_status = ST_SKIPPED;
      end else begin
        res.entry_status = chk_status;
        if (chk_status != ST_APPLIED) err_mid = 1'b1;
        else set_d = chk_next;
      end
      pos_d   = '0;
      shift_d = '0;
      emit    = 1'b1;
    end else begin
      shift_d = {shift_q[ShiftW-ByteW-1:0], s1_byte_q};
      pos_d   = pos_q + 3'd1;
      if (s1_last_q) begin
        res.entry_status = ST_TRUNCATED;
        err_mid = 1'b1;
        emit    = 1'b1;
      end
    end
    res.frame_done = s1_last_q;
    res.frame_ok   = !err_mid;
    res.settings   = set_d;
    err_d = err_mid;
    // end of payload returns the entry state to zero, settings persist
    if (s1_last_q) begin
      pos_d   = '0;
      shift_d = '0;
      err_d   = 1'b0;
    end
  end

  assign s1_adv     = s1_valid_q && (!emit || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) s1_valid_d = 1'b1;
    else if (s1_adv) s1_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      pos_q      <= '0;
      shift_q    <= '0;
      err_q      <= 1'b0;
      set_q      <= SETTINGS_RESET;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (s1_adv) begin
        pos_q   <= pos_d;
        shift_q <= shift_d;
        err_q   <= err_d;
        set_q   <= set_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  hsp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_adv && emit),
    .result_i    (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (res_q)
  );

  assign entry_id_o          = res_q.entry_id;
  assign entry_value_o       = res_q.entry_value;
  assign entry_status_o      = res_q.entry_status;
  assign frame_done_o        = res_q.frame_done;
  assign frame_ok_o          = res_q.frame_ok;
  assign table_size_o        = res_q.settings.table_size;
  assign push_enabled_o      = res_q.settings.push_enabled;
  assign max_streams_o       = res_q.settings.max_streams;
  assign window_size_o       = res_q.settings.window_size;
  assign frame_size_limit_o  = res_q.settings.frame_size_limit;
  assign header_list_limit_o = res_q.settings.header_list_limit;

endmodule
